// ----- sv/cst_pkg.sv -----
// shared types and constants for the connection slot table
package cst_pkg;

	localparam logic [15:0] EMPTY_IDENT = 16'hffff;

	typedef enum logic [2:0] {
		ACT_FIND_OR_CREATE = 3'd0,
		ACT_SET_ADDRESS    = 3'd1,
		ACT_START          = 3'd2,
		ACT_UPDATE         = 3'd3,
		ACT_STOP           = 3'd4,
		ACT_FIND_ID        = 3'd5,
		ACT_FIND_ADDRESS   = 3'd6,
		ACT_MARK_CACHED    = 3'd7
	} cst_action_t;

	typedef enum logic [1:0] {
		CFG_TARGET      = 2'd0,
		CFG_EARLY_LIMIT = 2'd1,
		CFG_PEER_REASON = 2'd2
	} cst_cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} cst_state_t;

	typedef struct packed {
		logic [7:0]  target;
		logic [15:0] early_limit;
		logic [7:0]  peer_reason;
	} cst_cfg_t;

	typedef struct packed {
		logic        alloc;
		logic        set_addr;
		logic        set_start;
		logic        set_update;
		logic        set_cached;
		logic        free;
		logic [15:0] ident;
		logic [47:0] addr;
		logic [31:0] now;
	} cst_wr_t;

	typedef struct packed {
		logic [15:0] ident;
		logic [47:0] addr;
		logic [31:0] hs_time;
		logic [31:0] start_time;
		logic [31:0] update_time;
		logic        cached;
	} cst_entry_t;

endpackage

// ----- sv/cst_slot_store.sv -----
// slot register file with one read port and one write port
module cst_slot_store #(
	parameter int SLOTS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
	input  cst_pkg::cst_wr_t                    wr,
	output cst_pkg::cst_entry_t                 rd
);

	logic [15:0] ident_q       [SLOTS];
	logic [47:0] addr_q        [SLOTS];
	logic [31:0] hs_time_q     [SLOTS];
	logic [31:0] start_time_q  [SLOTS];
	logic [31:0] update_time_q [SLOTS];
	logic        cached_q      [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ident_q[i] <= cst_pkg::EMPTY_IDENT;
			end
		end else if (wr.alloc) begin
			ident_q[idx] <= wr.ident;
		end else if (wr.free) begin
			ident_q[idx] <= cst_pkg::EMPTY_IDENT;
		end
	end

	// payload of a slot is rewritten on allocation, else single fields are set by the update commands
	always_ff @(posedge clk) begin
		if (wr.alloc) begin
			addr_q[idx]        <= wr.set_addr ? wr.addr : 48'd0;
			hs_time_q[idx]     <= wr.now;
			start_time_q[idx]  <= 32'd0;
			update_time_q[idx] <= 32'd0;
			cached_q[idx]      <= 1'b0;
		end else begin
			if (wr.set_addr) begin
				addr_q[idx] <= wr.addr;
			end
			if (wr.set_start) begin
				start_time_q[idx] <= wr.now;
			end
			if (wr.set_update) begin
				update_time_q[idx] <= wr.now;
			end
			if (wr.set_cached) begin
				cached_q[idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		rd.ident       = ident_q[idx];
		rd.addr        = addr_q[idx];
		rd.hs_time     = hs_time_q[idx];
		rd.start_time  = start_time_q[idx];
		rd.update_time = update_time_q[idx];
		rd.cached      = cached_q[idx];
	end

endmodule

// ----- sv/cst_seq.sv -----
// event sequencer: slot scan with one shared compare unit, then update and result
module cst_seq #(
	parameter int SLOTS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [2:0]                          action,
	input  logic [15:0]                         conn_ident,
	input  logic [47:0]                         peer_address,
	input  logic [7:0]                          stop_reason,
	input  logic [31:0]                         now_ms,
	input  cst_pkg::cst_cfg_t                   cfg,
	input  cst_pkg::cst_entry_t                 rd,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
	output cst_pkg::cst_wr_t                    wr,
	output logic                                busy,
	output logic                                done,
	output logic                                found,
	output logic [3:0]                          slot_index,
	output logic [15:0]                         matched_ident,
	output logic [7:0]                          active_count,
	output logic                                stop_advertising,
	output logic                                clear_session,
	output logic [47:0]                         session_address,
	output logic [31:0]                         duration_ms
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	cst_pkg::cst_state_t  state_q, state_next;
	cst_pkg::cst_action_t act_q;
	logic [15:0]          id_q;
	logic [47:0]          addr_q;
	logic [7:0]           reason_q;
	logic [31:0]          now_q;
	logic [IW-1:0]        ptr_q;
	logic [IW-1:0]        empty_idx_q;
	logic                 empty_seen_q;
	logic                 hit_q;
	logic                 alloc_q;
	logic [7:0]           count_q;

	logic                 done_q;
	logic                 found_q;
	logic [3:0]           slot_index_q;
	logic [15:0]          matched_ident_q;
	logic                 stop_adv_q;
	logic                 clear_q;
	logic [47:0]          session_addr_q;
	logic [31:0]          duration_q;

	logic                 is_last;
	logic                 is_empty;
	logic                 match;
	logic                 alloc_act;
	logic                 can_alloc;
	logic [IW-1:0]        alloc_idx;
	logic [31:0]          sub_b;
	logic [31:0]          diff;
	logic [7:0]           count_next;
	logic                 stop_adv_next;
	logic                 clear_next;
	logic [15:0]          ident_next;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			cst_pkg::ST_IDLE: begin
				if (start) begin
					state_next = cst_pkg::ST_SCAN;
				end
			end
			cst_pkg::ST_SCAN: begin
				if (match || is_last) begin
					state_next = cst_pkg::ST_EXEC;
				end
			end
			cst_pkg::ST_EXEC: begin
				state_next = cst_pkg::ST_IDLE;
			end
			default: begin
				state_next = cst_pkg::ST_IDLE;
			end
		endcase
	end

	// compare unit, subtractor and store commands
	always_comb begin
		is_last   = (ptr_q == LAST);
		is_empty  = (rd.ident == cst_pkg::EMPTY_IDENT);
		if (act_q == cst_pkg::ACT_FIND_ADDRESS) begin
			match = !is_empty && (rd.addr == addr_q);
		end else begin
			match = (id_q != cst_pkg::EMPTY_IDENT) && (rd.ident == id_q);
		end
		alloc_act = (act_q == cst_pkg::ACT_FIND_OR_CREATE) || (act_q == cst_pkg::ACT_SET_ADDRESS);
		can_alloc = alloc_act && (id_q != cst_pkg::EMPTY_IDENT) && (empty_seen_q || is_empty);
		alloc_idx = empty_seen_q ? empty_idx_q : ptr_q;

		sub_b = (act_q == cst_pkg::ACT_STOP) ? rd.start_time : rd.hs_time;
		diff  = now_q - sub_b;

		count_next = count_q;
		if (act_q == cst_pkg::ACT_START && count_q != 8'hff) begin
			count_next = count_q + 8'd1;
		end else if (act_q == cst_pkg::ACT_STOP && count_q != 8'd0) begin
			count_next = count_q - 8'd1;
		end
		stop_adv_next = hit_q && (act_q == cst_pkg::ACT_START) && (count_next >= cfg.target);
		clear_next    = hit_q && (act_q == cst_pkg::ACT_STOP) && (diff < {16'd0, cfg.early_limit})
			&& rd.cached && (reason_q == cfg.peer_reason);
		ident_next    = alloc_q ? id_q : rd.ident;

		idx           = ptr_q;
		wr.ident      = id_q;
		wr.addr       = addr_q;
		wr.now        = now_q;
		wr.alloc      = 1'b0;
		wr.set_addr   = 1'b0;
		wr.set_start  = 1'b0;
		wr.set_update = 1'b0;
		wr.set_cached = 1'b0;
		wr.free       = 1'b0;
		if (state_q == cst_pkg::ST_EXEC) begin
			wr.alloc      = alloc_q;
			wr.set_addr   = hit_q && (act_q == cst_pkg::ACT_SET_ADDRESS);
			wr.set_start  = hit_q && (act_q == cst_pkg::ACT_START);
			wr.set_update = hit_q && (act_q == cst_pkg::ACT_UPDATE);
			wr.set_cached = hit_q && (act_q == cst_pkg::ACT_MARK_CACHED);
			wr.free       = hit_q && (act_q == cst_pkg::ACT_STOP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			empty_idx_q  <= '0;
			empty_seen_q <= 1'b0;
			hit_q        <= 1'b0;
			alloc_q      <= 1'b0;
			count_q      <= 8'd0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				cst_pkg::ST_IDLE: begin
					if (start) begin
						ptr_q        <= '0;
						empty_seen_q <= 1'b0;
						hit_q        <= 1'b0;
						alloc_q      <= 1'b0;
					end
				end
				cst_pkg::ST_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
					end else if (is_last) begin
						if (can_alloc) begin
							ptr_q   <= alloc_idx;
							hit_q   <= 1'b1;
							alloc_q <= 1'b1;
						end
					end else begin
						if (is_empty && !empty_seen_q) begin
							empty_seen_q <= 1'b1;
							empty_idx_q  <= ptr_q;
						end
						ptr_q <= ptr_q + IW'(1);
					end
				end
				cst_pkg::ST_EXEC: begin
					count_q <= count_next;
					done_q  <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// event beat and result payload
	always_ff @(posedge clk) begin
		if (state_q == cst_pkg::ST_IDLE && start) begin
			act_q    <= cst_pkg::cst_action_t'(action);
			id_q     <= conn_ident;
			addr_q   <= peer_address;
			reason_q <= stop_reason;
			now_q    <= now_ms;
		end
		if (state_q == cst_pkg::ST_EXEC) begin
			found_q         <= hit_q;
			slot_index_q    <= hit_q ? 4'(ptr_q) : 4'd0;
			matched_ident_q <= hit_q ? ident_next : 16'd0;
			stop_adv_q      <= stop_adv_next;
			clear_q         <= clear_next;
			session_addr_q  <= clear_next ? rd.addr : 48'd0;
			if (hit_q && (act_q == cst_pkg::ACT_START || act_q == cst_pkg::ACT_STOP)) begin
				duration_q <= diff;
			end else begin
				duration_q <= 32'd0;
			end
		end
	end

	// outputs
	always_comb begin
		busy             = (state_q != cst_pkg::ST_IDLE);
		done             = done_q;
		found            = found_q;
		slot_index       = slot_index_q;
		matched_ident    = matched_ident_q;
		active_count     = count_q;
		stop_advertising = stop_adv_q;
		clear_session    = clear_q;
		session_address  = session_addr_q;
		duration_ms      = duration_q;
	end

`ifndef SYNTH
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == cst_pkg::ST_EXEC))
		else $error("result beat without update cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> slot_index == 4'd0 && matched_ident == 16'd0 && duration_ms == 32'd0)
		else $error("miss result carries slot data");

	a_flags_need_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (stop_advertising || clear_session) |-> found)
		else $error("flag raised without a slot");

	a_alloc_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		wr.alloc |-> !wr.free && hit_q && state_q == cst_pkg::ST_EXEC)
		else $error("allocation outside update cycle or with free");
`endif

endmodule

// ----- sv/connection_slot_table.sv -----
// connection slot table top level: configuration registers, sequencer and slot store
//
// An event beat is taken on a rising edge with start high and busy low; its fields are
// action, conn_ident, peer_address, stop_reason and now_ms. The sequencer then scans
// the slots one per cycle through a single compare unit, stopping at the first match,
// and then updates the slot and the active count in its update state.
// Busy stays high through the scan (1 to SLOTS slots) and the update.
// The result beat is shown for exactly one cycle with done high, the first cycle with
// busy low; a new start can be taken in that same cycle, and none while busy is high.
// The receiver cannot stall: it must take done when shown.
// Configuration is written through cfg_write, cfg_index and cfg_data with no wait.
// The user must write it only while no event is in flight; the block does not enforce
// this. Unknown indexes are ignored.
// Reset empties all slots, zeroes the active count and loads the register defaults
// (target 1, early limit 5000 ms, peer reason 19); no clearing pass is needed.
module connection_slot_table #(
	parameter int SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] conn_ident,
	input  logic [47:0] peer_address,
	input  logic [7:0]  stop_reason,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic        found,
	output logic [3:0]  slot_index,
	output logic [15:0] matched_ident,
	output logic [7:0]  active_count,
	output logic        stop_advertising,
	output logic        clear_session,
	output logic [47:0] session_address,
	output logic [31:0] duration_ms
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	cst_pkg::cst_cfg_t   cfg_q;
	cst_pkg::cst_wr_t    wr;
	cst_pkg::cst_entry_t rd;
	logic [IW-1:0]       idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target      <= 8'd1;
			cfg_q.early_limit <= 16'd5000;
			cfg_q.peer_reason <= 8'd19;
		end else if (cfg_write) begin
			case (cfg_index)
				cst_pkg::CFG_TARGET:      cfg_q.target      <= cfg_data[7:0];
				cst_pkg::CFG_EARLY_LIMIT: cfg_q.early_limit <= cfg_data;
				cst_pkg::CFG_PEER_REASON: cfg_q.peer_reason <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	cst_seq #(
		.SLOTS(SLOTS)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.action           (action),
		.conn_ident       (conn_ident),
		.peer_address     (peer_address),
		.stop_reason      (stop_reason),
		.now_ms           (now_ms),
		.cfg              (cfg_q),
		.rd               (rd),
		.idx              (idx),
		.wr               (wr),
		.busy             (busy),
		.done             (done),
		.found            (found),
		.slot_index       (slot_index),
		.matched_ident    (matched_ident),
		.active_count     (active_count),
		.stop_advertising (stop_advertising),
		.clear_session    (clear_session),
		.session_address  (session_address),
		.duration_ms      (duration_ms)
	);

	cst_slot_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.wr     (wr),
		.rd     (rd)
	);

endmodule

// ----- verif/slot_table_checker.sv -----
// checker for the connection slot table: mirrors the slots, predicts each result beat and compares it
module slot_table_checker
	import cst_pkg::*;
#(
	parameter int SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] conn_ident,
	input  logic [47:0] peer_address,
	input  logic [7:0]  stop_reason,
	input  logic [31:0] now_ms,
	input  logic        done,
	input  logic        found,
	input  logic [3:0]  slot_index,
	input  logic [15:0] matched_ident,
	input  logic [7:0]  active_count,
	input  logic        stop_advertising,
	input  logic        clear_session,
	input  logic [47:0] session_address,
	input  logic [31:0] duration_ms,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic        found;
		logic [3:0]  slot;
		logic [15:0] ident;
		logic [7:0]  count;
		logic        stop_adv;
		logic        clear;
		logic [47:0] sess_addr;
		logic [31:0] duration;
	} outcome_t;

	cst_entry_t slot_mem [SLOTS];
	logic [7:0] live_conns;
	cst_cfg_t   live_cfg;
	outcome_t   pending_outcomes [$];
	int         errors = 0;

	function automatic cst_entry_t empty_entry();
		cst_entry_t e;
		e = '0;
		e.ident = EMPTY_IDENT;
		return e;
	endfunction

	function automatic int find_ident(logic [15:0] id);
		if (id == EMPTY_IDENT)
			return -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot_mem[i].ident == id)
				return i;
		return -1;
	endfunction

	function automatic int claim_slot(logic [15:0] id, logic [31:0] now);
		int s;
		s = find_ident(id);
		if (s >= 0 || id == EMPTY_IDENT)
			return s;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_mem[i].ident == EMPTY_IDENT) begin
				slot_mem[i] = empty_entry();
				slot_mem[i].ident = id;
				slot_mem[i].hs_time = now;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic outcome_t table_outcome(cst_action_t act, logic [15:0] id,
			logic [47:0] addr, logic [7:0] reason, logic [31:0] now);
		outcome_t o;
		int s;
		o = '0;
		s = -1;
		case (act)
			ACT_FIND_OR_CREATE: s = claim_slot(id, now);
			ACT_SET_ADDRESS: begin
				s = claim_slot(id, now);
				if (s >= 0)
					slot_mem[s].addr = addr;
			end
			ACT_START: begin
				if (live_conns != 8'd255)
					live_conns++;
				s = find_ident(id);
				if (s >= 0) begin
					slot_mem[s].start_time = now;
					o.duration = now - slot_mem[s].hs_time;
					o.stop_adv = (live_conns >= live_cfg.target);
				end
			end
			ACT_UPDATE: begin
				s = find_ident(id);
				if (s >= 0)
					slot_mem[s].update_time = now;
			end
			ACT_STOP: begin
				if (live_conns != 8'd0)
					live_conns--;
				s = find_ident(id);
				if (s >= 0) begin
					o.duration = now - slot_mem[s].start_time;
					if (o.duration < 32'(live_cfg.early_limit) && slot_mem[s].cached &&
							reason == live_cfg.peer_reason) begin
						o.clear = 1'b1;
						o.sess_addr = slot_mem[s].addr;
					end
					o.ident = slot_mem[s].ident;
					slot_mem[s] = empty_entry();
				end
			end
			ACT_FIND_ID: s = find_ident(id);
			ACT_FIND_ADDRESS: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (slot_mem[i].ident != EMPTY_IDENT && slot_mem[i].addr == addr)
						s = i;
			end
			ACT_MARK_CACHED: begin
				s = find_ident(id);
				if (s >= 0)
					slot_mem[s].cached = 1'b1;
			end
			default: ;
		endcase
		if (s >= 0) begin
			o.found = 1'b1;
			o.slot = s[3:0];
			if (act != ACT_STOP)
				o.ident = slot_mem[s].ident;
		end
		o.count = live_conns;
		return o;
	endfunction

	task automatic compare_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_mem[i] = empty_entry();
			live_conns = '0;
			live_cfg.target = 8'd1;
			live_cfg.early_limit = 16'd5000;
			live_cfg.peer_reason = 8'd19;
			pending_outcomes.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					errors++;
					$error("result beat with no event pending");
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("found", 48'(want.found), 48'(found));
					compare_field("slot_index", 48'(want.slot), 48'(slot_index));
					compare_field("matched_ident", 48'(want.ident), 48'(matched_ident));
					compare_field("active_count", 48'(want.count), 48'(active_count));
					compare_field("stop_advertising", 48'(want.stop_adv),
						48'(stop_advertising));
					compare_field("clear_session", 48'(want.clear), 48'(clear_session));
					compare_field("session_address", want.sess_addr, session_address);
					compare_field("duration_ms", 48'(want.duration), 48'(duration_ms));
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_TARGET:      live_cfg.target = cfg_data[7:0];
					CFG_EARLY_LIMIT: live_cfg.early_limit = cfg_data;
					CFG_PEER_REASON: live_cfg.peer_reason = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_outcomes.push_back(table_outcome(cst_action_t'(action), conn_ident,
					peer_address, stop_reason, now_ms));
			outstanding <= pending_outcomes.size();
		end
		fail_count <= errors;
	end

endmodule

// ----- verif/connection_slot_table_tb.sv -----
// testbench top for the connection slot table: clock, reset, event and register stimulus, verdict
module connection_slot_table_tb;
	import cst_pkg::*;

	localparam int SLOTS = 4;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {MIX_LIFECYCLE, MIX_START_HEAVY, MIX_STOP_HEAVY} mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = '0;
	logic [15:0] conn_ident = '0;
	logic [47:0] peer_address = '0;
	logic [7:0]  stop_reason = '0;
	logic [31:0] now_ms = '0;
	logic        done;
	logic        found;
	logic [3:0]  slot_index;
	logic [15:0] matched_ident;
	logic [7:0]  active_count;
	logic        stop_advertising;
	logic        clear_session;
	logic [47:0] session_address;
	logic [31:0] duration_ms;
	int          fail_count;
	int          outstanding;
	int          cycles = 0;

	logic [15:0] id_pool [6];
	logic [47:0] addr_pool [4];
	int          stage [6];
	cst_action_t lifecycle [6] = '{ACT_FIND_OR_CREATE, ACT_SET_ADDRESS, ACT_MARK_CACHED,
		ACT_START, ACT_UPDATE, ACT_STOP};
	logic [31:0] clock_ms = '0;
	logic [7:0]  peer_reason = 8'd19;
	int          burst_left = 0;

	connection_slot_table #(.SLOTS(SLOTS)) dut (.*);

	slot_table_checker #(.SLOTS(SLOTS)) u_checker (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("connection_slot_table regression: fail");
			$finish;
		end
	end

	task automatic send_event(input cst_action_t act, input logic [15:0] id,
			input logic [47:0] addr, input logic [7:0] reason, input logic [31:0] now);
		action <= act;
		conn_ident <= id;
		peer_address <= addr;
		stop_reason <= reason;
		now_ms <= now;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle_and_configure(input logic [7:0] target, input logic [15:0] early,
			input logic [7:0] reason);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_TARGET;
		cfg_data <= {8'($urandom), target};
		@(posedge clk);
		cfg_index <= CFG_EARLY_LIMIT;
		cfg_data <= early;
		@(posedge clk);
		cfg_index <= CFG_PEER_REASON;
		cfg_data <= {8'($urandom), reason};
		@(posedge clk);
		cfg_write <= 1'b0;
		peer_reason = reason;
		burst_left = 0;
	endtask

	task automatic random_event(input mix_t mix);
		int p;
		int roll;
		cst_action_t act;
		logic [15:0] id;
		logic [47:0] addr;
		logic [7:0] reason;
		roll = $urandom_range(0, 99);
		p = $urandom_range(0, 5);
		id = id_pool[p];
		addr = addr_pool[$urandom_range(0, 3)];
		reason = ($urandom_range(0, 2) != 0) ? peer_reason : 8'($urandom);
		if ($urandom_range(0, 19) == 0)
			clock_ms = $urandom();
		else
			clock_ms += $urandom_range(0, 600);
		if (mix == MIX_START_HEAVY && roll < 85) begin
			act = ACT_START;
			if (roll < 40)
				id = 16'($urandom);
		end else if (mix == MIX_STOP_HEAVY && roll < 85) begin
			act = ACT_STOP;
			if (roll < 40)
				id = 16'($urandom);
		end else if (roll % 4 != 0) begin
			// follow the connection lifecycle of one pooled id
			act = lifecycle[stage[p]];
			stage[p] = (stage[p] + 1) % 6;
			if (act == ACT_MARK_CACHED && $urandom_range(0, 3) == 0)
				act = ACT_FIND_ID;
		end else begin
			act = cst_action_t'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: id = 16'($urandom);
				1: id = EMPTY_IDENT;
				default: ;
			endcase
			if ($urandom_range(0, 1) == 1)
				addr = {16'($urandom), 32'($urandom)};
		end
		send_event(act, id, addr, reason, clock_ms);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	initial begin
		for (int i = 0; i < 6; i++) begin
			id_pool[i] = 16'($urandom_range(0, 65534));
			stage[i] = 0;
		end
		addr_pool[0] = '0;
		for (int i = 1; i < 4; i++)
			addr_pool[i] = {16'($urandom), 32'($urandom)};
		clock_ms = $urandom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(ACT_FIND_ID, EMPTY_IDENT, '0, '0, '0);
		send_event(ACT_STOP, 16'h0000, '0, '0, '0);
		send_event(ACT_START, EMPTY_IDENT, '0, '0, 32'd10);
		send_event(ACT_FIND_OR_CREATE, 16'h0000, '0, '0, '0);
		send_event(ACT_SET_ADDRESS, 16'h0000, '1, '0, 32'd20);
		send_event(ACT_FIND_OR_CREATE, 16'hfffe, '0, '0, '1);
		send_event(ACT_SET_ADDRESS, 16'h0005, '0, '0, 32'd100);
		send_event(ACT_FIND_OR_CREATE, 16'h0007, '0, '0, 32'd200);
		// table full
		send_event(ACT_FIND_OR_CREATE, 16'h0009, '0, '0, 32'd300);
		send_event(ACT_SET_ADDRESS, 16'h0009, '1, '0, 32'd300);
		send_event(ACT_SET_ADDRESS, EMPTY_IDENT, '1, '0, 32'd300);
		// three occupied slots hold address zero
		send_event(ACT_FIND_ADDRESS, 16'h0000, '0, '0, 32'd300);
		send_event(ACT_FIND_ADDRESS, 16'h0000, '1, '0, 32'd300);
		send_event(ACT_FIND_ADDRESS, 16'h0000, 48'h123456789abc, '0, 32'd300);
		send_event(ACT_UPDATE, 16'h0007, '0, '0, 32'd400);
		send_event(ACT_UPDATE, 16'h0003, '0, '0, 32'd400);
		send_event(ACT_MARK_CACHED, 16'h0000, '0, '0, 32'd500);
		send_event(ACT_MARK_CACHED, 16'h0005, '0, '0, 32'd500);
		send_event(ACT_MARK_CACHED, 16'h0003, '0, '0, 32'd500);
		send_event(ACT_START, 16'h0000, '0, '0, 32'd1000);
		send_event(ACT_START, 16'hfffe, '0, '0, 32'd5);
		send_event(ACT_START, 16'h0005, '0, '0, 32'd1000);
		send_event(ACT_STOP, 16'h0000, '0, peer_reason, 32'd5999);
		send_event(ACT_STOP, 16'h0005, '0, peer_reason, 32'd6000);
		send_event(ACT_STOP, 16'hfffe, '0, peer_reason, 32'd6);
		send_event(ACT_STOP, 16'h1234, '0, peer_reason, 32'd7000);

		settle_and_configure(8'd0, 16'd0, 8'd0);
		repeat (130) random_event(MIX_LIFECYCLE);
		settle_and_configure(8'd255, 16'hffff, 8'd255);
		repeat (380) random_event(MIX_START_HEAVY);
		settle_and_configure(8'd2, 16'd5000, 8'd19);
		repeat (350) random_event(MIX_STOP_HEAVY);
		settle_and_configure(8'($urandom), 16'($urandom), 8'($urandom));
		repeat (120) random_event(MIX_LIFECYCLE);
		settle_and_configure(8'd3, 16'hffff, 8'd19);
		repeat (120) random_event(MIX_LIFECYCLE);

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("connection_slot_table regression: pass");
		else
			$display("connection_slot_table regression: fail");
		$finish;
	end

endmodule
